@@ sv/bbc_pkg.sv @@
// bbc_pkg: shared types, constants and helper functions for the bracket balance checker
// depends on nothing; imported by bbc_cfg_regs, bbc_stack and the top level
package bbc_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int PAIR_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_TDATA_W = 8;

    // special characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // reset values of the bracket pairs
    localparam logic [CHAR_W-1:0] RST_OPEN_A  = 8'd40;
    localparam logic [CHAR_W-1:0] RST_CLOSE_A = 8'd41;
    localparam logic [CHAR_W-1:0] RST_OPEN_B  = 8'd123;
    localparam logic [CHAR_W-1:0] RST_CLOSE_B = 8'd125;
    localparam logic [CHAR_W-1:0] RST_OPEN_C  = 8'd91;
    localparam logic [CHAR_W-1:0] RST_CLOSE_C = 8'd93;

    // pair indices
    localparam logic [PAIR_W-1:0] PAIR_A = 2'd0;
    localparam logic [PAIR_W-1:0] PAIR_B = 2'd1;
    localparam logic [PAIR_W-1:0] PAIR_C = 2'd2;

    // configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_A  = 3'd0,
        CFG_CLOSE_A = 3'd1,
        CFG_OPEN_B  = 3'd2,
        CFG_CLOSE_B = 3'd3,
        CFG_OPEN_C  = 3'd4,
        CFG_CLOSE_C = 3'd5
    } cfg_idx_e;

    // character classes
    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_OPEN  = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_SPACE = 2'd3
    } kind_e;

    typedef struct packed {
        logic [CHAR_W-1:0] open_a;
        logic [CHAR_W-1:0] close_a;
        logic [CHAR_W-1:0] open_b;
        logic [CHAR_W-1:0] close_b;
        logic [CHAR_W-1:0] open_c;
        logic [CHAR_W-1:0] close_c;
    } pair_chars_t;

    typedef struct packed {
        kind_e             kind;
        logic [PAIR_W-1:0] pair;
    } class_t;

    // request from the line logic to the stack
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [PAIR_W-1:0] pair;
    } stack_cmd_t;

    // stack status seen by the line logic
    typedef struct packed {
        logic              empty;
        logic              full;
        logic [PAIR_W-1:0] top;
    } stack_stat_t;

    // classify a character; first hit in pair order wins, space between close a and open b
    function automatic class_t classify(input pair_chars_t pc, input logic [CHAR_W-1:0] c);
        class_t r;
        r.kind = KIND_OTHER;
        r.pair = PAIR_A;
        if (pc.open_a == c) begin
            r.kind = KIND_OPEN;
            r.pair = PAIR_A;
        end else if (pc.close_a == c) begin
            r.kind = KIND_CLOSE;
            r.pair = PAIR_A;
        end else if (c == CH_SPACE) begin
            r.kind = KIND_SPACE;
        end else if (pc.open_b == c) begin
            r.kind = KIND_OPEN;
            r.pair = PAIR_B;
        end else if (pc.close_b == c) begin
            r.kind = KIND_CLOSE;
            r.pair = PAIR_B;
        end else if (pc.open_c == c) begin
            r.kind = KIND_OPEN;
            r.pair = PAIR_C;
        end else if (pc.close_c == c) begin
            r.kind = KIND_CLOSE;
            r.pair = PAIR_C;
        end
        return r;
    endfunction

    // a popped pair matches c if any pair with the same opener closes with c
    function automatic logic pair_match(input pair_chars_t pc, input logic [PAIR_W-1:0] popped,
                                        input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] opener;
        opener = pc.open_a;
        if (popped == PAIR_B) begin
            opener = pc.open_b;
        end else if (popped == PAIR_C) begin
            opener = pc.open_c;
        end
        return ((pc.open_a == opener) && (pc.close_a == c)) ||
               ((pc.open_b == opener) && (pc.close_b == c)) ||
               ((pc.open_c == opener) && (pc.close_c == c));
    endfunction

endpackage

@@ sv/bbc_ram.sv @@
// bbc_ram: generic single-write, single-read synchronous ram with registered read data
// depends on nothing
module bbc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/bbc_cfg_regs.sv @@
// bbc_cfg_regs: bracket pair character registers behind the configuration write channel
// depends on bbc_pkg
module bbc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbc_pkg::CHAR_W-1:0]    cfg_data,
    output bbc_pkg::pair_chars_t          chars
);
    import bbc_pkg::*;

    pair_chars_t chars_reg;
    pair_chars_t chars_next;

    assign cfg_ready = 1'b1;
    assign chars     = chars_reg;

    // decode the register index; indices past the list are dropped
    always_comb begin
        chars_next = chars_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OPEN_A:  chars_next.open_a  = cfg_data;
                CFG_CLOSE_A: chars_next.close_a = cfg_data;
                CFG_OPEN_B:  chars_next.open_b  = cfg_data;
                CFG_CLOSE_B: chars_next.close_b = cfg_data;
                CFG_OPEN_C:  chars_next.open_c  = cfg_data;
                CFG_CLOSE_C: chars_next.close_c = cfg_data;
                default:     chars_next = chars_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_reg.open_a  <= RST_OPEN_A;
            chars_reg.close_a <= RST_CLOSE_A;
            chars_reg.open_b  <= RST_OPEN_B;
            chars_reg.close_b <= RST_CLOSE_B;
            chars_reg.open_c  <= RST_OPEN_C;
            chars_reg.close_c <= RST_CLOSE_C;
        end else begin
            chars_reg <= chars_next;
        end
    end

endmodule

@@ sv/bbc_stack.sv @@
// bbc_stack: pair stack held in a synchronous ram, with a depth counter and top forwarding
// depends on bbc_pkg and bbc_ram
module bbc_stack (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bbc_pkg::stack_cmd_t    cmd,
    output bbc_pkg::stack_stat_t   stat
);
    import bbc_pkg::*;

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               fwd_valid_reg;
    logic [PAIR_W-1:0]  fwd_data_reg;
    logic [ADDR_W-1:0]  top_idx;
    logic [PAIR_W-1:0]  rd_data;

    // depth update
    always_comb begin
        depth_next = depth_reg;
        if (cmd.clear) begin
            depth_next = '0;
        end else if (cmd.push) begin
            depth_next = depth_reg + DEPTH_W'(1);
        end else if (cmd.pop) begin
            depth_next = depth_reg - DEPTH_W'(1);
        end
    end

    // read the entry that will be on top next cycle
    assign top_idx = depth_next[ADDR_W-1:0] - ADDR_W'(1);

    bbc_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.push),
        .wr_addr (depth_reg[ADDR_W-1:0]),
        .wr_data (cmd.pair),
        .rd_addr (top_idx),
        .rd_data (rd_data)
    );

    // a push writes the very entry being read, so the pushed pair is forwarded in the following cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            depth_reg     <= depth_next;
            fwd_valid_reg <= cmd.push;
        end
        fwd_data_reg <= cmd.pair;
    end

    assign stat.empty = (depth_reg == '0);
    assign stat.full  = (depth_reg == DEPTH_W'(STACK_DEPTH));
    assign stat.top   = fwd_valid_reg ? fwd_data_reg : rd_data;

endmodule

@@ sv/bracket_balance_checker.sv @@
// bracket_balance_checker: top level, line state, result register and channel handshakes
// depends on bbc_pkg, bbc_cfg_regs and bbc_stack
//
// Usage:
//   s_ channel: one character word per transfer, s_tdata[7:0] = char_code.
//   m_ channel: one result word per newline, m_tdata bit 0 = balanced,
//     bit 1 = overflowed, bits 7:2 zero. Other characters give no word.
//   cfg channel: cfg_index 0..5 selects open/close char of pairs a, b, c;
//     higher indices are ignored. Always ready; write only while idle.
// Output: the result word is registered, appearing the cycle after its newline is taken.
// Throughput: one character per cycle while no stall holds s_tready low. The stack
//   top comes from a ram read at the next depth, so its data is the new top, with a
//   forward of the word just pushed, so pushes and pops run back to back.
// Stall: s_tready is low only while a result word is held and m_tready is low;
//   a held word stays until taken, and the next character is taken in the
//   same cycle the held word leaves.
// Reset (aresetn low, synchronous): stack empty, line state cleared, no result
//   held, bracket pairs back to ( ), { }, [ ]. No clearing pass is needed.
module bracket_balance_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input characters
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // [7:0] char_code
    // line results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // [0] balanced, [1] overflowed, [7:2] zero
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bbc_pkg::CHAR_W-1:0]    cfg_data
);
    import bbc_pkg::*;

    pair_chars_t chars;
    stack_cmd_t  cmd;
    stack_stat_t stat;
    class_t      cls;

    logic        in_fire;
    logic        line_failed_reg;
    logic        line_failed_next;
    logic        overflow_seen_reg;
    logic        overflow_seen_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [1:0]  result_reg;
    logic [1:0]  result_next;

    bbc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .chars     (chars)
    );

    bbc_stack u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign cls      = classify(chars, s_tdata);

    // per-character line logic
    always_comb begin
        cmd                = '0;
        cmd.pair           = cls.pair;
        line_failed_next   = line_failed_reg;
        overflow_seen_next = overflow_seen_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        result_next        = result_reg;
        if (in_fire) begin
            if (s_tdata == CH_NEWLINE) begin
                m_tvalid_next      = 1'b1;
                result_next        = {overflow_seen_reg, !line_failed_reg && stat.empty};
                cmd.clear          = 1'b1;
                line_failed_next   = 1'b0;
                overflow_seen_next = 1'b0;
            end else if (!line_failed_reg) begin
                unique case (cls.kind)
                    KIND_OPEN: begin
                        if (stat.full) begin
                            overflow_seen_next = 1'b1;
                            line_failed_next   = 1'b1;
                        end else begin
                            cmd.push = 1'b1;
                        end
                    end
                    KIND_CLOSE: begin
                        if (stat.empty) begin
                            line_failed_next = 1'b1;
                        end else begin
                            cmd.pop = 1'b1;
                            if (!pair_match(chars, stat.top, s_tdata)) begin
                                line_failed_next = 1'b1;
                            end
                        end
                    end
                    KIND_SPACE: begin
                        line_failed_next = line_failed_reg;
                    end
                    KIND_OTHER: begin
                        line_failed_next = 1'b1;
                    end
                    default: begin
                        line_failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_failed_reg   <= 1'b0;
            overflow_seen_reg <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            line_failed_reg   <= line_failed_next;
            overflow_seen_reg <= overflow_seen_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
        result_reg <= result_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(OUT_TDATA_W - 2)'(0), result_reg};

endmodule

@@ tb/bracket_balance_checker_tb.sv @@
`timescale 1ns / 100ps
// bracket_balance_checker_tb: self-checking bench for the bracket balance checker
// depends on bbc_pkg and bracket_balance_checker; streams text lines through the block,
// predicts each line verdict in the bench and compares every result word
module bracket_balance_checker_tb;
    import bbc_pkg::*;

    localparam int PHASE_CHARS   = 240;
    localparam int HOLD_CYCLES   = 200;
    localparam int HOLD_AFTER    = 20;
    // longest quiet stretch is the receiver hold plus a stall burst and a register write
    localparam int WATCHDOG_LIMIT = 4 * (HOLD_CYCLES + 16);
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_PRINTED   = 30;

    // register slots beyond the six pair characters, writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam logic [CHAR_W-1:0] CH_LT = 8'd60;
    localparam logic [CHAR_W-1:0] CH_GT = 8'd62;

    typedef struct packed {
        logic balanced;
        logic overflowed;
    } line_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;    // [7:0] char_code
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;           // [0] balanced, [1] overflowed, [7:2] zero
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_OPEN_A;
    logic [CHAR_W-1:0]    cfg_data  = '0;

    // bench copy of the pair characters, shared by the line generator and the predictor
    logic [CHAR_W-1:0] open_ch  [3] = '{RST_OPEN_A, RST_OPEN_B, RST_OPEN_C};
    logic [CHAR_W-1:0] close_ch [3] = '{RST_CLOSE_A, RST_CLOSE_B, RST_CLOSE_C};

    // predicted line state
    logic [PAIR_W-1:0] nest_stack [STACK_DEPTH];
    int                nest_depth = 0;
    logic              line_bad   = 1'b0;
    logic              line_ovf   = 1'b0;
    line_result_t      line_results [$];

    // stimulus bookkeeping
    logic [CHAR_W-1:0] pending_chars [$];
    int chars_queued = 0;
    int chars_taken  = 0;
    int idle_pct     = 20;
    int send_gap     = 0;
    int take_gap     = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int quiet_cycles = 0;

    int mismatches       = 0;
    int lines_checked    = 0;
    int lines_balanced   = 0;
    int lines_overflowed = 0;
    int reg_writes       = 0;

    bracket_balance_checker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // advance the line state by one character, queue a verdict on newline
    task automatic scan_char(input logic [CHAR_W-1:0] c);
        kind_e             cls;
        int                pair;
        int                i;
        logic [CHAR_W-1:0] opener;
        logic              closes;
        line_result_t      verdict;
        cls = KIND_OTHER;
        pair = 0;
        if (c == CH_NEWLINE) begin
            verdict.balanced   = !line_bad && (nest_depth == 0);
            verdict.overflowed = line_ovf;
            line_results.push_back(verdict);
            nest_depth = 0;
            line_bad   = 1'b0;
            line_ovf   = 1'b0;
        end else if (!line_bad) begin
            // pairs in order, space sits between the first pair and the rest
            for (i = 0; i < 3 && cls == KIND_OTHER; i++) begin
                if (open_ch[i] == c) begin
                    cls = KIND_OPEN;
                    pair = i;
                end else if (close_ch[i] == c) begin
                    cls = KIND_CLOSE;
                    pair = i;
                end else if (c == CH_SPACE) begin
                    cls = KIND_SPACE;
                end
            end
            case (cls)
                KIND_OPEN: begin
                    if (nest_depth >= STACK_DEPTH) begin
                        line_ovf = 1'b1;
                        line_bad = 1'b1;
                    end else begin
                        nest_stack[nest_depth] = pair[PAIR_W-1:0];
                        nest_depth++;
                    end
                end
                KIND_CLOSE: begin
                    if (nest_depth == 0) begin
                        line_bad = 1'b1;
                    end else begin
                        nest_depth--;
                        // any pair sharing the popped opener may close it
                        opener = open_ch[nest_stack[nest_depth]];
                        closes = 1'b0;
                        for (i = 0; i < 3; i++) begin
                            if (open_ch[i] == opener && close_ch[i] == c) begin
                                closes = 1'b1;
                            end
                        end
                        if (!closes) begin
                            line_bad = 1'b1;
                        end
                    end
                end
                KIND_SPACE: ;
                default: line_bad = 1'b1;
            endcase
        end
    endtask

    // sender: one word per accepted character, random idle bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_tvalid && !s_tready) begin
            // word still waiting, hold it
        end else if (send_gap != 0) begin
            s_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_chars.size() != 0 && idle_pct != 0 &&
                     $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            send_gap <= $urandom_range(0, 7);
        end else if (pending_chars.size() != 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= pending_chars.pop_front();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // long receiver hold once the run is under way, so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && lines_checked >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // receiver: ready with random stall bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            take_gap <= 0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
        end else if (take_gap != 0) begin
            m_tready <= 1'b0;
            take_gap <= take_gap - 1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            m_tready <= 1'b0;
            take_gap <= $urandom_range(0, 7);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // predict on accepted characters, then check accepted result words
    always @(posedge aclk) begin : scoreboard
        line_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                scan_char(s_tdata);
                chars_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (line_results.size() == 0) begin
                    flag_mismatch("result word with no line pending", m_tdata, 0);
                end else begin
                    want = line_results.pop_front();
                    lines_checked++;
                    if (want.balanced) lines_balanced++;
                    if (want.overflowed) lines_overflowed++;
                    if (m_tdata[0] !== want.balanced)
                        flag_mismatch("balanced", m_tdata[0], want.balanced);
                    if (m_tdata[1] !== want.overflowed)
                        flag_mismatch("overflowed", m_tdata[1], want.overflowed);
                    if (m_tdata[7:2] !== 6'd0)
                        flag_mismatch("pad bits", m_tdata[7:2], 0);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, line_results.size());
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAR_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_OPEN_A:  open_ch[0]  = value;
            CFG_CLOSE_A: close_ch[0] = value;
            CFG_OPEN_B:  open_ch[1]  = value;
            CFG_CLOSE_B: close_ch[1] = value;
            CFG_OPEN_C:  open_ch[2]  = value;
            CFG_CLOSE_C: close_ch[2] = value;
            default: ;
        endcase
    endtask

    task automatic load_pairs(input logic [CHAR_W-1:0] oa, input logic [CHAR_W-1:0] ca,
                              input logic [CHAR_W-1:0] ob, input logic [CHAR_W-1:0] cb,
                              input logic [CHAR_W-1:0] oc, input logic [CHAR_W-1:0] cc);
        write_reg(CFG_OPEN_A, oa);
        write_reg(CFG_CLOSE_A, ca);
        write_reg(CFG_OPEN_B, ob);
        write_reg(CFG_CLOSE_B, cb);
        write_reg(CFG_OPEN_C, oc);
        write_reg(CFG_CLOSE_C, cc);
    endtask

    // block is idle once every character is in and every verdict is out
    task automatic wait_idle();
        while (chars_taken != chars_queued || line_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_char(input logic [CHAR_W-1:0] c);
        pending_chars.push_back(c);
        chars_queued++;
    endtask

    task automatic queue_str(input string text);
        int i;
        for (i = 0; i < text.len(); i++) begin
            queue_char(text[i]);
        end
        queue_char(CH_NEWLINE);
    endtask

    // straight run of openers then their closers, deep enough to fill or overflow the stack
    task automatic queue_deep_line(input int n_open);
        int pairs [$];
        int i;
        int p;
        for (i = 0; i < n_open; i++) begin
            p = $urandom_range(0, 2);
            pairs.push_back(p);
            queue_char(open_ch[p]);
        end
        while (pairs.size() != 0) begin
            queue_char(close_ch[pairs.pop_back()]);
        end
        queue_char(CH_NEWLINE);
    endtask

    // well-formed nesting with spaces, optionally broken at one spot
    task automatic queue_nested_line(input int len, input int max_nest, input bit broken);
        int                open_pairs [$];
        logic [CHAR_W-1:0] text [$];
        int                p;
        int                at;
        int                i;
        while (text.size() < len || open_pairs.size() != 0) begin
            if (text.size() < len && $urandom_range(0, 9) == 0) begin
                text.push_back(CH_SPACE);
            end else if (text.size() < len && open_pairs.size() < max_nest &&
                         (open_pairs.size() == 0 || $urandom_range(0, 1) == 1)) begin
                p = $urandom_range(0, 2);
                open_pairs.push_back(p);
                text.push_back(open_ch[p]);
            end else begin
                p = open_pairs.pop_back();
                text.push_back(close_ch[p]);
            end
        end
        if (broken && text.size() != 0) begin
            at = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 2))
                0: text[at] = CHAR_W'($urandom_range(0, 255));
                1: text[at] = close_ch[$urandom_range(0, 2)];
                default: text.delete(at);
            endcase
        end
        for (i = 0; i < text.size(); i++) begin
            queue_char(text[i]);
        end
        queue_char(CH_NEWLINE);
    endtask

    // unstructured mix of bracket characters, spaces and arbitrary bytes
    task automatic queue_soup_line(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 3))
                0: queue_char(open_ch[$urandom_range(0, 2)]);
                1: queue_char(close_ch[$urandom_range(0, 2)]);
                2: queue_char(CH_SPACE);
                default: queue_char(CHAR_W'($urandom_range(0, 255)));
            endcase
        end
        queue_char(CH_NEWLINE);
    endtask

    task automatic random_lines(input int n);
        int start;
        int pick;
        start = chars_queued;
        while (chars_queued - start < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                queue_nested_line($urandom_range(0, 12), $urandom_range(1, 8), 1'b0);
            end else if (pick < 77) begin
                queue_nested_line($urandom_range(1, 12), $urandom_range(1, 8), 1'b1);
            end else if (pick < 98) begin
                queue_soup_line($urandom_range(0, 10));
            end else begin
                queue_deep_line($urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3));
            end
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed lines on the reset pairs
        queue_str("");
        queue_str("({[]})");
        queue_str(")");
        queue_str("(]");
        queue_str("( ");
        queue_char(8'h00);
        queue_str(")");
        queue_char(8'hFF);
        queue_str("()");
        wait_idle();

        // space and newline as pair characters, pair c shares the opener of pair a
        load_pairs(RST_OPEN_A, RST_CLOSE_A, CH_SPACE, CH_NEWLINE, RST_OPEN_A, CH_GT);
        write_reg(CFG_SPARE_LO, 8'hFF);
        write_reg(CFG_SPARE_HI, 8'h00);
        queue_str("( >");
        queue_str("(>)");
        queue_str(" ");
        wait_idle();

        // reset pairs, exactly full and overflowing stacks first
        load_pairs(RST_OPEN_A, RST_CLOSE_A, RST_OPEN_B, RST_CLOSE_B, RST_OPEN_C, RST_CLOSE_C);
        queue_deep_line(STACK_DEPTH);
        queue_deep_line(STACK_DEPTH + 2);
        random_lines(PHASE_CHARS);
        wait_idle();

        // extreme character codes
        idle_pct = 25;
        load_pairs(8'h00, 8'hFF, 8'h01, 8'hFE, 8'h7F, 8'h80);
        random_lines(PHASE_CHARS);
        wait_idle();

        // arbitrary pairs, no idling in this stretch
        idle_pct = 0;
        load_pairs(CHAR_W'($urandom_range(0, 255)), CHAR_W'($urandom_range(0, 255)),
                   CHAR_W'($urandom_range(0, 255)), CHAR_W'($urandom_range(0, 255)),
                   CHAR_W'($urandom_range(0, 255)), CHAR_W'($urandom_range(0, 255)));
        write_reg(CFG_SPARE_LO, CHAR_W'($urandom_range(0, 255)));
        write_reg(CFG_SPARE_HI, CHAR_W'($urandom_range(0, 255)));
        random_lines(PHASE_CHARS);
        wait_idle();

        // shared openers and a pair whose opener is its own closer
        idle_pct = 20;
        load_pairs(RST_OPEN_A, RST_CLOSE_A, RST_OPEN_A, RST_CLOSE_C, CH_LT, CH_LT);
        random_lines(PHASE_CHARS);
        wait_idle();

        // closing stretch on the reset pairs at full rate
        idle_pct = 0;
        load_pairs(RST_OPEN_A, RST_CLOSE_A, RST_OPEN_B, RST_CLOSE_B, RST_OPEN_C, RST_CLOSE_C);
        random_lines(PHASE_CHARS);
        wait_idle();

        $display("ran %0d characters as %0d lines across %0d register writes",
                 chars_taken, lines_checked, reg_writes);
        $display("%0d lines balanced, %0d overflowed the stack, %0d mismatches",
                 lines_balanced, lines_overflowed, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/bbc_pkg.sv
sv/bbc_ram.sv
sv/bbc_cfg_regs.sv
sv/bbc_stack.sv
sv/bracket_balance_checker.sv
tb/bracket_balance_checker_tb.sv
